/* sv/swrl_pkg.sv */
package swrl_pkg;

    // field and register widths
    localparam int DATA_W      = 32;
    localparam int VAL_W       = 48;
    localparam int WIN_W       = 7;
    localparam int MEAS_W      = 3;
    localparam int N_RATE      = 4;
    localparam int N_AMOUNT    = 4;
    localparam int LIMIT_W     = DATA_W + WIN_W;
    localparam int CFG_AW      = 5;
    localparam int IN_TDATA_W  = DATA_W * (1 + N_AMOUNT);
    localparam int OUT_TDATA_W = 8;

    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    // register reset values
    localparam logic [WIN_W-1:0]  WINDOW_RST   = 7'd10;
    localparam logic [MEAS_W-1:0] MEASURES_RST = 3'd2;
    localparam logic [N_RATE-1:0][DATA_W-1:0] RATE_RST = {
        32'd0, 32'd0, 32'd104857600, 32'd1000
    };

    typedef enum logic [2:0] {
        REG_WINDOW   = 3'd0,
        REG_MEASURES = 3'd1,
        REG_RATE0    = 3'd2,
        REG_RATE1    = 3'd3,
        REG_RATE2    = 3'd4,
        REG_RATE3    = 3'd5
    } t_reg_idx;

    typedef enum logic [0:0] {
        KIND_CHECK  = 1'b0,
        KIND_COMMIT = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADV,
        S_MOD,
        S_STEP,
        S_DRAIN,
        S_CMP,
        S_RD,
        S_WR,
        S_OUT
    } t_state;

    // strobes from the sequencer to every lane
    typedef struct packed {
        logic clr_hist;
        logic clr_pend;
        logic load_pend;
        logic sub_en;
        logic rd_valid;
        logic cmp_en;
        logic wr_en;
    } t_lane_ctl;

endpackage

/* sv/swrl_mod.sv */
module swrl_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [swrl_pkg::DATA_W-1:0]   i_dividend,
    input  logic [swrl_pkg::WIN_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [swrl_pkg::WIN_W-1:0]    o_rem
);
    import swrl_pkg::*;

    localparam int STEP_BITS = 4;
    localparam int N_STEPS   = DATA_W / STEP_BITS;
    localparam int CNT_W     = $clog2(N_STEPS);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DATA_W-1:0]  r_dvd;
    logic [WIN_W-1:0]   r_div;
    logic [WIN_W-1:0]   r_rem;
    logic [WIN_W-1:0]   n_rem;
    logic [WIN_W:0]     step_t;

    // four restoring steps per cycle, remainder only
    always_comb begin
        n_rem  = r_rem;
        step_t = '0;
        for (int k = 0; k < STEP_BITS; k++) begin
            step_t = {n_rem, r_dvd[DATA_W-1-k]};
            if (step_t >= {1'b0, r_div}) begin
                step_t = step_t - {1'b0, r_div};
            end
            n_rem = step_t[WIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(N_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << STEP_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* sv/swrl_lane.sv */
module swrl_lane #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swrl_pkg::t_lane_ctl           i_ctl,
    input  logic [AW-1:0]                 i_addr,
    input  logic [swrl_pkg::DATA_W-1:0]   i_amount,
    input  logic [swrl_pkg::DATA_W-1:0]   i_rate,
    input  logic [swrl_pkg::WIN_W-1:0]    i_weff,
    input  logic                          i_active,
    output logic                          o_exceed
);
    import swrl_pkg::*;

    logic [VAL_W-1:0]   r_mem [DEPTH];
    logic [VAL_W-1:0]   r_rd_data;
    logic [VAL_W-1:0]   r_total;
    logic [DATA_W-1:0]  r_pend;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_exceed;

    logic [VAL_W-1:0]   rd_eff;
    logic [VAL_W:0]     sum;
    logic [VAL_W-1:0]   add;
    logic [VAL_W-1:0]   total_new;
    logic [VAL_W-1:0]   bucket_new;

    // saturating accumulate: add at most what keeps the total in range
    always_comb begin
        rd_eff = i_ctl.rd_valid ? r_rd_data : '0;
        sum    = {1'b0, r_total} + (VAL_W + 1)'(r_pend);
        if (!i_active) begin
            add       = '0;
            total_new = r_total;
        end else if (sum[VAL_W]) begin
            add       = VAL_MAX - r_total;
            total_new = VAL_MAX;
        end else begin
            add       = VAL_W'(r_pend);
            total_new = sum[VAL_W-1:0];
        end
        bucket_new = rd_eff + add;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= bucket_new;
        end
        r_rd_data <= r_mem[i_addr];
        r_limit   <= LIMIT_W'(i_rate) * LIMIT_W'(i_weff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_pend   <= '0;
            r_exceed <= 1'b0;
        end else begin
            if (i_ctl.clr_hist) begin
                r_total <= '0;
            end else if (i_ctl.sub_en) begin
                r_total <= r_total - rd_eff;
            end else if (i_ctl.wr_en) begin
                r_total <= total_new;
            end
            if (i_ctl.clr_pend) begin
                r_pend <= '0;
            end else if (i_ctl.load_pend) begin
                r_pend <= i_amount;
            end
            if (i_ctl.cmp_en) begin
                r_exceed <= i_active && (sum > (VAL_W + 1)'(r_limit));
            end
        end
    end

    assign o_exceed = r_exceed;

endmodule

/* sv/sliding_window_rate_limiter.sv */
// sliding-window rate limiter over up to MAX_MEASURES measures. each measure lane keeps one
// 48-bit bucket per second in its own ring memory of MAX_SECONDS entries plus a running window
// total; a row valid bit per second (shared by all lanes) stands for a cleared row, so reset and
// reconfiguration need no clearing pass. a check transfer (tuser 0) moves time to now_seconds,
// drops the buckets of skipped seconds, and returns disallowed = 1 if any measure in use would
// go past rate_limit * window; a commit transfer (tuser 1) adds the amounts of the last check to
// the current second. one result transfer per input transfer, in order. a check that advances
// time inside the window drops the bucket row of each skipped second (one bucket row is read
// and subtracted per cycle) before the compare; a commit reads, then writes the current bucket
// row. the ring position is last_second mod window, found by a 4-bit-per-cycle remainder unit
// whenever it is unknown: first use after reset or after a window or measure-count write, a
// jump of a whole window or more, or time going backward. writing window_seconds or
// measures_in_use clears all history and pending amounts; registers must be written only while
// idle, which the block itself does not enforce
module sliding_window_rate_limiter #(
    parameter int MAX_SECONDS  = 64,
    parameter int MAX_MEASURES = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [swrl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // now_seconds, amount_0..amount_3
    input  logic [0:0]                         s_axis_tuser,  // kind
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [swrl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // disallowed, zero padding
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [swrl_pkg::CFG_AW-1:0]        paddr,
    input  logic [swrl_pkg::DATA_W-1:0]        pwdata,
    output logic [swrl_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import swrl_pkg::*;

    localparam int AW = (MAX_SECONDS > 1) ? $clog2(MAX_SECONDS) : 1;

    // configuration registers
    logic [WIN_W-1:0]               r_window;
    logic [MEAS_W-1:0]              r_measures;
    logic [N_RATE-1:0][DATA_W-1:0]  r_rate;

    // sequencer state
    t_state                         r_state;
    t_state                         n_state;
    t_kind                          r_kind;
    logic [DATA_W-1:0]              r_now;
    logic [DATA_W-1:0]              r_last;
    logic [AW-1:0]                  r_pos;
    logic                           r_pos_ok;
    logic [WIN_W-1:0]               r_cnt;
    logic [MAX_SECONDS-1:0]         r_valid;
    logic                           r_sub_en;
    logic                           r_rd_vld;
    logic                           r_out_vld;
    logic                           r_out_flag;

    logic                           cfg_wr;
    t_reg_idx                       cfg_idx;
    logic                           cfg_clear;
    logic [WIN_W-1:0]               w_eff;
    logic [MEAS_W-1:0]              m_eff;
    logic                           w_zero;
    logic                           accept;
    logic                           out_free;
    logic                           t_fwd;
    logic [DATA_W-1:0]              t_delta;
    logic                           t_jump;
    logic                           adv_check;
    logic [AW-1:0]                  next_pos;
    logic [AW-1:0]                  lane_addr;
    logic                           mod_start;
    logic                           mod_done;
    logic [WIN_W-1:0]               mod_rem;
    t_lane_ctl                      lane_ctl;
    logic [MAX_MEASURES-1:0]        lane_exceed;

    // ------------------------------------------------------------------
    // register port, always ready
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite & pready;
    assign cfg_idx   = t_reg_idx'(paddr[CFG_AW-1:2]);
    // window and measure-count writes throw away all history
    assign cfg_clear = cfg_wr && (cfg_idx == REG_WINDOW || cfg_idx == REG_MEASURES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= WINDOW_RST;
            r_measures <= MEASURES_RST;
            r_rate     <= RATE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WINDOW:   r_window   <= pwdata[WIN_W-1:0];
                REG_MEASURES: r_measures <= pwdata[MEAS_W-1:0];
                REG_RATE0:    r_rate[0]  <= pwdata;
                REG_RATE1:    r_rate[1]  <= pwdata;
                REG_RATE2:    r_rate[2]  <= pwdata;
                REG_RATE3:    r_rate[3]  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WINDOW:   prdata = DATA_W'(r_window);
            REG_MEASURES: prdata = DATA_W'(r_measures);
            REG_RATE0:    prdata = r_rate[0];
            REG_RATE1:    prdata = r_rate[1];
            REG_RATE2:    prdata = r_rate[2];
            REG_RATE3:    prdata = r_rate[3];
            default:      prdata = '0;
        endcase
    end

    // window and measure count saturate at what the storage holds
    assign w_eff  = (int'(r_window) > MAX_SECONDS) ? WIN_W'(MAX_SECONDS) : r_window;
    assign m_eff  = (int'(r_measures) > MAX_MEASURES) ? MEAS_W'(MAX_MEASURES) : r_measures;
    assign w_zero = (w_eff == '0);

    // ------------------------------------------------------------------
    // time advance decode
    // ------------------------------------------------------------------
    assign accept    = s_axis_tvalid & s_axis_tready;
    assign out_free  = !r_out_vld || m_axis_tready;
    assign t_fwd     = (r_now > r_last);
    assign t_delta   = r_now - r_last;
    // a jump of a whole window or more empties every bucket at once
    assign t_jump    = t_fwd && (t_delta >= DATA_W'(w_eff));
    assign adv_check = (r_state == S_ADV) && (r_kind == KIND_CHECK) && !w_zero;

    // ring position of the next second, wrapping at the window length
    assign next_pos  = (32'(r_pos) + 32'd1 == 32'(w_eff)) ? '0 : r_pos + AW'(1);
    assign lane_addr = (r_state == S_STEP) ? next_pos : r_pos;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        mod_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_ADV;
            end
            S_ADV: begin
                if (r_kind == KIND_CHECK) begin
                    if (w_zero || !t_fwd || t_jump) begin
                        n_state = S_CMP;
                    end else if (r_pos_ok) begin
                        n_state = S_STEP;
                    end else begin
                        n_state   = S_MOD;
                        mod_start = 1'b1;
                    end
                end else begin
                    if (w_zero) begin
                        n_state = S_OUT;
                    end else if (r_pos_ok) begin
                        n_state = S_RD;
                    end else begin
                        n_state   = S_MOD;
                        mod_start = 1'b1;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) n_state = (r_kind == KIND_CHECK) ? S_STEP : S_RD;
            end
            S_STEP: begin
                if (r_cnt == WIN_W'(1)) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_CMP;
            S_CMP:   n_state = S_OUT;
            S_RD:    n_state = S_WR;
            S_WR:    n_state = S_OUT;
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last    <= '0;
            r_pos_ok  <= 1'b0;
            r_valid   <= '0;
            r_sub_en  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            // bucket read in a step cycle is subtracted in the next one
            r_sub_en <= (r_state == S_STEP);

            if (adv_check) begin
                r_last <= r_now;
                if (t_jump) begin
                    r_valid  <= '0;
                    r_pos_ok <= 1'b0;
                end else if (!t_fwd && r_now != r_last) begin
                    // time went backward: position must be recomputed
                    r_pos_ok <= 1'b0;
                end
            end
            if (r_state == S_MOD && mod_done) begin
                r_pos_ok <= 1'b1;
            end
            if (r_state == S_STEP) begin
                r_valid[next_pos] <= 1'b0;
            end
            if (r_state == S_WR) begin
                r_valid[r_pos] <= 1'b1;
            end
            if (cfg_clear) begin
                r_valid  <= '0;
                r_pos_ok <= 1'b0;
            end

            // result register, parted from the input side
            if (r_state == S_OUT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= t_kind'(s_axis_tuser[0]);
            r_now  <= s_axis_tdata[DATA_W-1:0];
        end
        if (r_state == S_ADV) begin
            r_cnt <= t_delta[WIN_W-1:0];
        end else if (r_state == S_STEP) begin
            r_cnt <= r_cnt - WIN_W'(1);
        end
        if (r_state == S_MOD && mod_done) begin
            r_pos <= AW'(mod_rem);
        end else if (r_state == S_STEP) begin
            r_pos <= next_pos;
        end
        // row valid bit sampled alongside the memory read
        r_rd_vld <= r_valid[lane_addr];
        if (r_state == S_OUT && out_free) begin
            r_out_flag <= (r_kind == KIND_CHECK) && (|lane_exceed);
        end
    end

    // last_second mod window
    swrl_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_last),
        .i_divisor  (w_eff),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // ------------------------------------------------------------------
    // measure lanes
    // ------------------------------------------------------------------
    assign lane_ctl.clr_hist  = cfg_clear || (adv_check && t_jump);
    assign lane_ctl.clr_pend  = cfg_clear;
    assign lane_ctl.load_pend = accept && (t_kind'(s_axis_tuser[0]) == KIND_CHECK);
    assign lane_ctl.sub_en    = r_sub_en;
    assign lane_ctl.rd_valid  = r_rd_vld;
    assign lane_ctl.cmp_en    = (r_state == S_CMP);
    assign lane_ctl.wr_en     = (r_state == S_WR);

    for (genvar g = 0; g < MAX_MEASURES; g++) begin : g_lane
        swrl_lane #(
            .DEPTH (MAX_SECONDS),
            .AW    (AW)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (lane_ctl),
            .i_addr   (lane_addr),
            .i_amount (s_axis_tdata[DATA_W*(g+1) +: DATA_W]),
            .i_rate   (r_rate[g]),
            .i_weff   (w_eff),
            .i_active (MEAS_W'(g) < m_eff),
            .o_exceed (lane_exceed[g])
        );
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_flag);

endmodule

/* sv/swrl_checker.sv */
module swrl_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [swrl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import swrl_pkg::*;

    // reset leaves no result pending and the input open
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("result pending or input closed after reset");

    // one item at a time: busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again while an item is in flight");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // padding above the flag stays zero
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:1] == '0)
        else $error("result padding not zero");

endmodule

bind sliding_window_rate_limiter swrl_checker u_swrl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
